/* rtl/dqtm_pkg.sv */
// Shared types and command codes for the delta-list timer queue.
package dqtm_pkg;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_CLOSE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [0:0] CFG_MIN_TIMEOUT = 1'd0;
    localparam logic [0:0] CFG_MAX_TIMEOUT = 1'd1;

    localparam int unsigned TIMEOUT_W = 16;

    // Control from the sequencer to every cell of the chain.
    typedef struct packed {
        logic shift;     // every cell takes its upstream neighbour's contents
        logic load;      // every cell takes its load input: the next cell's contents on a pop, else its own
    } dqtm_cell_ctrl_t;

endpackage

/* rtl/delta_queue_timer_manager_core.sv */
// Top level of the delta-list timer queue: sequencer, reload store and cell chain.
//
//  channel   signals                                         transaction when
//  command   start, busy, func..irq_pending                  start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//  result    result_strobe, fired_valid..last                result_strobe
//
// The list sits in a ring of NUM_TIMERS cells, packed from cell 0; a walk rotates
// the ring once. A start walks it to remove, then to insert; a close walks it to
// remove; an ignored command goes straight to the final result. A tick on a
// non-empty list walks once to spill the elapsed time, then pops each expired
// timer and walks again to put each periodic one back.
// Reset empties the list and restores the registers; there is no clearing pass.
// The final result is on the ports in the last busy cycle; the receiver cannot stall.
module delta_queue_timer_manager_core #(
    parameter int unsigned NUM_TIMERS  = 16,
    parameter int unsigned DELAY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        func,
    input  logic [3:0]                        timer_id,
    input  logic [31:0]                       first_delay,
    input  logic [31:0]                       reload_delay,
    input  logic [15:0]                       hw_counter,
    input  logic [15:0]                       elapsed_ticks,
    input  logic                              irq_pending,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    output logic                              result_strobe,
    output logic                              fired_valid,
    output logic [3:0]                        fired_id,
    output logic                              program_valid,
    output logic [15:0]                       program_interval,
    output logic                              last
);
    import dqtm_pkg::*;

    localparam int unsigned ID_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned DW   = DELAY_WIDTH;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REMOVE = 3'd1;
    localparam logic [2:0] ST_INSERT = 3'd2;
    localparam logic [2:0] ST_SPILL  = 3'd3;
    localparam logic [2:0] ST_FIRE   = 3'd4;
    localparam logic [2:0] ST_RELOAD = 3'd5;
    localparam logic [2:0] ST_FINAL  = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [1:0]      func_reg, func_next;
    logic [ID_W-1:0] sid_reg, sid_next;
    logic [15:0]     hw_reg, hw_next;
    logic            pend_reg, pend_next;
    logic [DW-1:0]   acc_reg, acc_next;
    logic            hit_reg, hit_next;
    logic            carry_v_reg, carry_v_next;
    logic [ID_W-1:0] carry_id_reg, carry_id_next;
    logic [DW-1:0]   carry_d_reg, carry_d_next;
    logic [ID_W-1:0] cnt_reg, cnt_next;
    logic            touched_reg, touched_next;
    logic [15:0]     min_reg, min_next;
    logic [15:0]     max_reg, max_next;

    logic [DW-1:0]   reload_mem [NUM_TIMERS];
    logic [DW-1:0]   reload_rd_reg;
    logic            reload_we;

    dqtm_cell_ctrl_t ctrl;
    logic            c_valid [NUM_TIMERS];
    logic [ID_W-1:0] c_id    [NUM_TIMERS];
    logic [DW-1:0]   c_delta [NUM_TIMERS];
    logic            in_valid;
    logic [ID_W-1:0] in_id;
    logic [DW-1:0]   in_delta;
    logic            pop;

    logic            head_v;
    logic [ID_W-1:0] head_i;
    logic [DW-1:0]   head_d;
    logic            pass_end;
    logic            match;
    logic            id_ok;
    logic            accept;
    logic [DW-1:0]   fin_d;
    logic [15:0]     fin_int;
    logic            fin_prog;

    // Cell 0 is the head; the chain shifts towards it and the tail takes in_*.
    // A load either pops the head or rewrites the head delta in place.
    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            logic             up_v;
            logic [ID_W-1:0]  up_i;
            logic [DW-1:0]    up_d;
            logic             ld_v;
            logic [ID_W-1:0]  ld_i;
            logic [DW-1:0]    ld_d;
            if (g == NUM_TIMERS - 1)
            begin : g_tail
                assign up_v = in_valid;
                assign up_i = in_id;
                assign up_d = in_delta;
                assign ld_v = pop ? 1'b0 : c_valid[g];
                assign ld_i = c_id[g];
                assign ld_d = c_delta[g];
            end
            else if (g == 0)
            begin : g_head
                assign up_v = c_valid[1];
                assign up_i = c_id[1];
                assign up_d = c_delta[1];
                assign ld_v = pop ? c_valid[1] : c_valid[0];
                assign ld_i = pop ? c_id[1] : c_id[0];
                assign ld_d = pop ? c_delta[1] : fin_d;
            end
            else
            begin : g_body
                assign up_v = c_valid[g+1];
                assign up_i = c_id[g+1];
                assign up_d = c_delta[g+1];
                assign ld_v = pop ? c_valid[g+1] : c_valid[g];
                assign ld_i = pop ? c_id[g+1] : c_id[g];
                assign ld_d = pop ? c_delta[g+1] : c_delta[g];
            end
            dqtm_cell #(.ID_W(ID_W), .DLY_W(DW)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .up_valid (up_v),
                .up_id    (up_i),
                .up_delta (up_d),
                .ld_valid (ld_v),
                .ld_id    (ld_i),
                .ld_delta (ld_d),
                .valid    (c_valid[g]),
                .id       (c_id[g]),
                .delta    (c_delta[g])
            );
        end
    endgenerate

    assign head_v    = c_valid[0];
    assign head_i    = c_id[0];
    assign head_d    = c_delta[0];
    assign pass_end  = (cnt_reg == ID_W'(NUM_TIMERS - 1));
    assign match     = head_v && (head_i == sid_reg);
    assign id_ok     = (32'(timer_id) < 32'(NUM_TIMERS));
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign pop       = (state_reg == ST_FIRE);

    // Interval update from the head of the list.
    always_comb
    begin
        fin_d    = head_d;
        fin_prog = 1'b0;
        fin_int  = '0;
        if (touched_reg)
        begin
            if (!head_v)
            begin
                fin_prog = 1'b1;
                fin_int  = max_reg;
            end
            else if (!pend_reg)
            begin
                if (head_d < DW'(hw_reg) || head_d < DW'(min_reg))
                begin
                    fin_d = DW'(min_reg);
                end
                else
                begin
                    fin_d = head_d - DW'(hw_reg);
                end
                fin_prog = 1'b1;
                fin_int  = (fin_d > DW'(max_reg)) ? max_reg : fin_d[15:0];
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        sid_next         = sid_reg;
        hw_next          = hw_reg;
        pend_next        = pend_reg;
        acc_next         = acc_reg;
        hit_next         = hit_reg;
        carry_v_next     = carry_v_reg;
        carry_id_next    = carry_id_reg;
        carry_d_next     = carry_d_reg;
        cnt_next         = cnt_reg;
        touched_next     = touched_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        ctrl             = '0;
        in_valid         = head_v;
        in_id            = head_i;
        in_delta         = head_d;
        reload_we        = 1'b0;
        result_strobe    = 1'b0;
        fired_valid      = 1'b0;
        fired_id         = '0;
        program_valid    = 1'b0;
        program_interval = '0;
        last             = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MIN_TIMEOUT)
            begin
                min_next = cfg_data;
            end
            else
            begin
                max_next = cfg_data;
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next    = func;
                    sid_next     = ID_W'(timer_id);
                    hw_next      = hw_counter;
                    pend_next    = irq_pending;
                    acc_next     = (func == FUNC_TICK) ? DW'(elapsed_ticks)
                                                       : DW'(first_delay) + DW'(hw_counter);
                    hit_next     = 1'b0;
                    carry_v_next = 1'b0;
                    cnt_next     = '0;
                    touched_next = 1'b0;
                    if ((func == FUNC_START || func == FUNC_CLOSE) && id_ok)
                    begin
                        reload_we    = (func == FUNC_START);
                        touched_next = (func == FUNC_START);
                        state_next   = ST_REMOVE;
                    end
                    else if (func == FUNC_TICK && head_v)
                    begin
                        touched_next = 1'b1;
                        state_next   = ST_SPILL;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_REMOVE:
            begin
                // Once the slot is passed, every later entry moves up one cell.
                ctrl.shift = 1'b1;
                if (hit_reg)
                begin
                    in_valid = c_valid[1];
                    in_id    = c_id[1];
                    in_delta = c_delta[1];
                end
                else if (match)
                begin
                    hit_next = 1'b1;
                    in_valid = c_valid[1];
                    in_id    = c_id[1];
                    in_delta = c_valid[1] ? c_delta[1] + head_d : c_delta[1];
                end
                cnt_next = cnt_reg + 1'b1;
                if (pass_end)
                begin
                    if (hit_reg || match)
                    begin
                        in_valid = 1'b0;
                    end
                    cnt_next = '0;
                    hit_next = 1'b0;
                    if (func_reg == FUNC_START)
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        touched_next = hit_reg || match;
                        state_next   = ST_FINAL;
                    end
                end
            end
            ST_INSERT:
            begin
                // After the new entry goes in, each entry is held back one cell.
                ctrl.shift = 1'b1;
                if (!hit_reg)
                begin
                    if (!head_v || head_d > acc_reg)
                    begin
                        in_valid      = 1'b1;
                        in_id         = sid_reg;
                        in_delta      = acc_reg;
                        hit_next      = 1'b1;
                        carry_v_next  = head_v;
                        carry_id_next = head_i;
                        carry_d_next  = head_d - acc_reg;
                    end
                    else
                    begin
                        acc_next = acc_reg - head_d;
                    end
                end
                else
                begin
                    in_valid      = carry_v_reg;
                    in_id         = carry_id_reg;
                    in_delta      = carry_d_reg;
                    carry_v_next  = head_v;
                    carry_id_next = head_i;
                    carry_d_next  = head_d;
                end
                cnt_next = cnt_reg + 1'b1;
                if (pass_end)
                begin
                    cnt_next     = '0;
                    hit_next     = 1'b0;
                    carry_v_next = 1'b0;
                    state_next   = (func_reg == FUNC_TICK) ? ST_FIRE : ST_FINAL;
                end
            end
            ST_SPILL:
            begin
                ctrl.shift = 1'b1;
                if (head_v && !hit_reg)
                begin
                    if (head_d >= acc_reg)
                    begin
                        in_delta = head_d - acc_reg;
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_reg - head_d;
                        in_delta = '0;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (pass_end)
                begin
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE:
            begin
                if (head_v && head_d == '0)
                begin
                    ctrl.load     = 1'b1;
                    result_strobe = 1'b1;
                    fired_valid   = 1'b1;
                    fired_id      = 4'(head_i);
                    sid_next      = head_i;
                    state_next    = ST_RELOAD;
                end
                else
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_RELOAD:
            begin
                if (reload_rd_reg != '0)
                begin
                    acc_next     = reload_rd_reg;
                    hit_next     = 1'b0;
                    carry_v_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_INSERT;
                end
                else
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_FINAL:
            begin
                result_strobe    = 1'b1;
                last             = 1'b1;
                program_valid    = fin_prog;
                program_interval = fin_int;
                if (touched_reg && head_v && !pend_reg)
                begin
                    ctrl.load = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            func_reg     <= FUNC_START;
            sid_reg      <= '0;
            hw_reg       <= '0;
            pend_reg     <= 1'b0;
            acc_reg      <= '0;
            hit_reg      <= 1'b0;
            carry_v_reg  <= 1'b0;
            carry_id_reg <= '0;
            carry_d_reg  <= '0;
            cnt_reg      <= '0;
            touched_reg  <= 1'b0;
            min_reg      <= 16'd2;
            max_reg      <= 16'd65535;
        end
        else
        begin
            state_reg    <= state_next;
            func_reg     <= func_next;
            sid_reg      <= sid_next;
            hw_reg       <= hw_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            hit_reg      <= hit_next;
            carry_v_reg  <= carry_v_next;
            carry_id_reg <= carry_id_next;
            carry_d_reg  <= carry_d_next;
            cnt_reg      <= cnt_next;
            touched_reg  <= touched_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reload_rd_reg <= reload_mem[head_i];
        if (reload_we)
        begin
            reload_mem[ID_W'(timer_id)] <= DW'(reload_delay);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !busy)
        else $error("busy after final result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && fired_valid) |-> !last)
        else $error("fired result marked last");
endmodule

/* rtl/dqtm_cell.sv */
// One cell of the timer chain: a slot number, its delta and a valid bit.
module dqtm_cell #(
    parameter int unsigned ID_W  = 4,
    parameter int unsigned DLY_W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dqtm_pkg::dqtm_cell_ctrl_t ctrl,
    input  logic                     up_valid,
    input  logic [ID_W-1:0]          up_id,
    input  logic [DLY_W-1:0]         up_delta,
    input  logic                     ld_valid,
    input  logic [ID_W-1:0]          ld_id,
    input  logic [DLY_W-1:0]         ld_delta,
    output logic                     valid,
    output logic [ID_W-1:0]          id,
    output logic [DLY_W-1:0]         delta
);
    import dqtm_pkg::*;

    logic             valid_reg, valid_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [DLY_W-1:0] delta_reg, delta_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        delta_next = delta_reg;
        if (ctrl.load)
        begin
            valid_next = ld_valid;
            id_next    = ld_id;
            delta_next = ld_delta;
        end
        else if (ctrl.shift)
        begin
            valid_next = up_valid;
            id_next    = up_id;
            delta_next = up_delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        delta_reg <= delta_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign delta = delta_reg;
endmodule

/* test/delta_queue_timer_manager_core_checker.sv */
// Checker for the delta-list timer queue: predicts every result and compares it.
`timescale 1ns / 1ps

module delta_queue_timer_manager_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [3:0]  timer_id,
    input  logic [31:0] first_delay,
    input  logic [31:0] reload_delay,
    input  logic [15:0] hw_counter,
    input  logic [15:0] elapsed_ticks,
    input  logic        irq_pending,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        result_strobe,
    input  logic        fired_valid,
    input  logic [3:0]  fired_id,
    input  logic        program_valid,
    input  logic [15:0] program_interval,
    input  logic        last,
    output int          mismatches,
    output int          pending_results
);
    import dqtm_pkg::*;

    localparam int NT = 16;
    localparam logic [4:0] NIL = 5'd16;

    typedef struct packed {
        logic        fired_valid;
        logic [3:0]  fired_id;
        logic        program_valid;
        logic [15:0] program_interval;
        logic        last;
    } timer_result_t;

    timer_result_t expected_results[$];

    logic [15:0] min_to, max_to;
    logic [31:0] delta_q[NT];
    logic [31:0] reload_q[NT];
    logic [4:0]  link_q[NT];
    logic        queued_q[NT];
    logic [4:0]  head_q;

    task automatic unlink_timer(input int s);
        int prev;
        int it;
        int n;
        prev = int'(NIL);
        it = head_q;
        n = 0;
        if (!queued_q[s])
            return;
        while (it < NT && n < NT)
        begin
            if (it == s)
            begin
                if (link_q[it] < NT)
                    delta_q[link_q[it]] = delta_q[link_q[it]] + delta_q[it];
                if (prev < NT)
                    link_q[prev] = link_q[it];
                else
                    head_q = link_q[it];
                break;
            end
            prev = it;
            it = link_q[it];
            n++;
        end
        queued_q[s] = 1'b0;
    endtask

    task automatic insert_timer(input int s);
        int prev;
        int it;
        int n;
        prev = int'(NIL);
        it = head_q;
        n = 0;
        while (it < NT && n < NT)
        begin
            if (delta_q[it] > delta_q[s])
            begin
                delta_q[it] = delta_q[it] - delta_q[s];
                break;
            end
            delta_q[s] = delta_q[s] - delta_q[it];
            prev = it;
            it = link_q[it];
            n++;
        end
        if (prev >= NT)
        begin
            link_q[s] = head_q;
            head_q = s[4:0];
        end
        else
        begin
            link_q[prev] = s[4:0];
            link_q[s] = (it < NT) ? it[4:0] : NIL;
        end
        queued_q[s] = 1'b1;
    endtask

    task automatic next_interval(input logic [15:0] hw, input logic pend,
                                 inout timer_result_t r);
        logic [31:0] d;
        if (head_q >= NT)
        begin
            r.program_valid = 1'b1;
            r.program_interval = max_to;
            return;
        end
        if (pend)
            return;
        d = delta_q[head_q];
        if (d < 32'(hw) || d < 32'(min_to))
            d = 32'(min_to);
        else
            d = d - 32'(hw);
        delta_q[head_q] = d;
        r.program_valid = 1'b1;
        r.program_interval = (d > 32'(max_to)) ? max_to : d[15:0];
    endtask

    task automatic predict_command();
        timer_result_t r;
        logic [31:0] cnt;
        int it;
        int n;
        int fired;
        int s;
        fired = 0;
        if (func == FUNC_TICK && head_q < NT)
        begin
            cnt = 32'(elapsed_ticks);
            it = head_q;
            n = 0;
            while (it < NT && n < NT)
            begin
                if (delta_q[it] >= cnt)
                begin
                    delta_q[it] = delta_q[it] - cnt;
                    break;
                end
                cnt = cnt - delta_q[it];
                delta_q[it] = '0;
                it = link_q[it];
                n++;
            end
            n = 0;
            while (head_q < NT && delta_q[head_q] == 0 && n < NT)
            begin
                s = head_q;
                head_q = link_q[s];
                queued_q[s] = 1'b0;
                r = '0;
                r.fired_valid = 1'b1;
                r.fired_id = s[3:0];
                expected_results.push_back(r);
                fired++;
                n++;
                if (reload_q[s] != 0)
                begin
                    delta_q[s] = reload_q[s];
                    insert_timer(s);
                end
            end
        end
        r = '0;
        r.last = 1'b1;
        if (func == FUNC_START)
        begin
            unlink_timer(timer_id);
            delta_q[timer_id] = first_delay + 32'(hw_counter);
            reload_q[timer_id] = reload_delay;
            insert_timer(timer_id);
            next_interval(hw_counter, irq_pending, r);
        end
        else if (func == FUNC_CLOSE)
        begin
            if (queued_q[timer_id])
            begin
                unlink_timer(timer_id);
                next_interval(hw_counter, irq_pending, r);
            end
        end
        else if (func == FUNC_TICK)
        begin
            if (head_q < NT || fired > 0)
                next_interval(hw_counter, irq_pending, r);
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t got;
        timer_result_t want;
        if (!rst_n)
        begin
            min_to <= 16'd2;
            max_to <= 16'hFFFF;
            head_q = NIL;
            for (int i = 0; i < NT; i++)
            begin
                queued_q[i] = 1'b0;
                delta_q[i] = '0;
                reload_q[i] = '0;
                link_q[i] = '0;
            end
            expected_results.delete();
            mismatches <= 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIN_TIMEOUT)
                    min_to <= cfg_data;
                else
                    max_to <= cfg_data;
            end
            if (result_strobe)
            begin
                got = '{fired_valid, fired_id, program_valid, program_interval, last};
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %p", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                predict_command();
            pending_results = expected_results.size();
        end
    end

endmodule

/* test/delta_queue_timer_manager_core_tb.sv */
// Testbench top: drives commands and register writes and reports the verdict.
`timescale 1ns / 1ps

module delta_queue_timer_manager_core_tb;
    import dqtm_pkg::*;

    localparam logic [1:0] FUNC_UNDEF = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [3:0]  timer_id;
    logic [31:0] first_delay;
    logic [31:0] reload_delay;
    logic [15:0] hw_counter;
    logic [15:0] elapsed_ticks;
    logic        irq_pending;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_strobe;
    logic        fired_valid;
    logic [3:0]  fired_id;
    logic        program_valid;
    logic [15:0] program_interval;
    logic        last;
    int          mismatches;
    int          pending_results;

    delta_queue_timer_manager_core dut (.*);
    delta_queue_timer_manager_core_checker checker_i (.*);

    always #5 clk = ~clk;

    task automatic send_command(input logic [1:0] f, input logic [3:0] id,
                                input logic [31:0] fd, input logic [31:0] rd,
                                input logic [15:0] hw, input logic [15:0] el,
                                input logic irq);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (gap) @(posedge clk);
        @(posedge clk);
        start <= 1'b1;
        func <= f;
        timer_id <= id;
        first_delay <= fd;
        reload_delay <= rd;
        hw_counter <= hw;
        elapsed_ticks <= el;
        irq_pending <= irq;
        @(posedge clk);
        start <= 1'b0;
    endtask

    task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
        @(negedge clk);
        while (busy || pending_results != 0)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_delay();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    task automatic random_command();
        logic [1:0]  f;
        logic [31:0] rd;
        int pick;
        pick = $urandom_range(0, 9);
        f = pick < 4 ? FUNC_START : (pick < 6 ? FUNC_CLOSE : (pick < 9 ? FUNC_TICK : FUNC_UNDEF));
        rd = $urandom_range(0, 1) ? 32'd0 : random_delay();
        send_command(f, 4'($urandom), random_delay(), rd,
                     16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                     16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)),
                     $urandom_range(0, 4) == 0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_START;
        timer_id = '0;
        first_delay = '0;
        reload_delay = '0;
        hw_counter = '0;
        elapsed_ticks = '0;
        irq_pending = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_TIMEOUT;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(FUNC_TICK, 4'd0, 32'd0, 32'd0, 16'd5, 16'd5, 1'b0);
        send_command(FUNC_CLOSE, 4'd3, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        send_command(FUNC_START, 4'd0, 32'd100, 32'd50, 16'd0, 16'd0, 1'b0);
        send_command(FUNC_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                     16'd0, 1'b0);
        send_command(FUNC_START, 4'd7, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        send_command(FUNC_START, 4'd8, 32'd100, 32'd0, 16'd3, 16'd0, 1'b1);
        send_command(FUNC_START, 4'd0, 32'd30, 32'd30, 16'd1, 16'd0, 1'b0);
        send_command(FUNC_START, 4'd9, 32'd200000, 32'd0, 16'd0, 16'd0, 1'b0);
        send_command(FUNC_UNDEF, 4'd1, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        send_command(FUNC_TICK, 4'd0, 32'd0, 32'd0, 16'd0, 16'd40, 1'b0);
        send_command(FUNC_TICK, 4'd0, 32'd0, 32'd0, 16'd0, 16'hFFFF, 1'b1);
        send_command(FUNC_CLOSE, 4'd9, 32'd0, 32'd0, 16'd10, 16'd0, 1'b0);
        send_command(FUNC_CLOSE, 4'd15, 32'd0, 32'd0, 16'd0, 16'd0, 1'b1);
        send_command(FUNC_TICK, 4'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin write_register(CFG_MIN_TIMEOUT, 16'd1);
                         write_register(CFG_MAX_TIMEOUT, 16'd100); end
                1: begin write_register(CFG_MIN_TIMEOUT, 16'hFFFF);
                         write_register(CFG_MAX_TIMEOUT, 16'hFFFF); end
                2: begin write_register(CFG_MIN_TIMEOUT, 16'd50);
                         write_register(CFG_MAX_TIMEOUT, 16'd1); end
                3: begin write_register(CFG_MIN_TIMEOUT, 16'($urandom));
                         write_register(CFG_MAX_TIMEOUT, 16'($urandom)); end
                default: begin write_register(CFG_MIN_TIMEOUT, 16'd2);
                               write_register(CFG_MAX_TIMEOUT, 16'd500); end
            endcase
            for (int i = 0; i < 50; i++)
                random_command();
        end

        @(negedge clk);
        while (busy || pending_results != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
